// ----- sv/ole_pkg.sv -----
// ---------------------------------------------------------------------------
// ole_pkg
// Shared types and constants for the ordered list engine: operation codes,
// status codes and the data word width.
// ---------------------------------------------------------------------------
package ole_pkg;

    // Width of one stored entry and of the value and key fields.
    localparam int DATA_W = 32;

    // Width of the position field of a result word.
    localparam int POS_W = 6;

    // Operation carried by an input word.
    typedef enum logic [2:0] {
        K_INS_FRONT = 3'd0,
        K_INS_END   = 3'd1,
        K_INS_AFTER = 3'd2,
        K_DEL_FRONT = 3'd3,
        K_DEL_END   = 3'd4,
        K_DEL_VALUE = 3'd5,
        K_SEARCH    = 3'd6,
        K_DUMP      = 3'd7
    } kind_t;

    // Status reported with each result word.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

endpackage

// ----- sv/ole_ram.sv -----
// ---------------------------------------------------------------------------
// ole_ram
// Entry store: one write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module ole_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/ordered_list_engine.sv -----
// ---------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of up to DEPTH signed values kept packed in one entry memory.
// ---------------------------------------------------------------------------
// The block takes one operation word at a time and stalls its request side
// until that operation has handed its last result to the output register.
// All work goes through the entry memory, one read and one write per cycle,
// so the cost follows the list length L. Search, insert-after and
// delete-by-value read one entry per cycle up to the match and then shift
// only the entries behind it; a search, or a miss, ends with the scan. A
// dump reads each entry and then hands it to the output register. Any
// stall on the result side delays the result words.
// The memory needs no clearing after reset: only entries below the current
// length are ever read.
module ordered_list_engine #(
    parameter int DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [2:0]                       kind,
    input  logic signed [ole_pkg::DATA_W-1:0] value,
    input  logic signed [ole_pkg::DATA_W-1:0] key,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [1:0]                       status,
    output logic [ole_pkg::POS_W-1:0]        position,
    output logic signed [ole_pkg::DATA_W-1:0] entry,
    output logic                             last
);

    import ole_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [LW-1:0] LEN_MAX = LW'(DEPTH);
    localparam logic [LW-1:0] ONE     = LW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_RESP
    } state_t;

    state_t              state_reg, state_next;
    kind_t               kind_reg, kind_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [DATA_W-1:0]   key_reg, key_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [LW-1:0]       src_reg, src_next;
    logic [LW-1:0]       mv_reg, mv_next;
    logic [LW-1:0]       pos_reg, pos_next;
    logic [LW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                cmp_pend_reg, cmp_pend_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       dst_reg, dst_next;
    logic                up_reg, up_next;
    status_t             res_status_reg, res_status_next;
    logic [POS_W-1:0]    res_pos_reg, res_pos_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [1:0]          rsp_status_reg, rsp_status_next;
    logic [POS_W-1:0]    rsp_pos_reg, rsp_pos_next;
    logic [DATA_W-1:0]   rsp_entry_reg, rsp_entry_next;
    logic                rsp_last_reg, rsp_last_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    logic                full;
    logic                empty;
    logic                out_free;
    logic [DATA_W-1:0]   target;
    logic [LW-1:0]       src_inc;
    logic [LW-1:0]       src_dec;
    logic [LW-1:0]       cmp_inc;
    logic                dump_last;

    ole_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Helper terms used by the sequencer.
    assign full      = (len_reg == LEN_MAX);
    assign empty     = (len_reg == '0);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign target    = (kind_reg == K_INS_AFTER) ? key_reg : value_reg;
    assign src_inc   = src_reg + ONE;
    assign src_dec   = src_reg - ONE;
    assign cmp_inc   = cmp_idx_reg + ONE;
    assign dump_last = (src_inc == len_reg);

    assign req_stall = (state_reg != S_IDLE);

    // Sequencer: decodes the word, scans, shifts and emits results.
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        value_next      = value_reg;
        key_next        = key_reg;
        len_next        = len_reg;
        src_next        = src_reg;
        mv_next         = mv_reg;
        pos_next        = pos_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_pend_next   = cmp_pend_reg;
        pend_next       = pend_reg;
        dst_next        = dst_reg;
        up_next         = up_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;

        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_status_next = rsp_status_reg;
        rsp_pos_next    = rsp_pos_reg;
        rsp_entry_next  = rsp_entry_reg;
        rsp_last_next   = rsp_last_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next       = kind_t'(kind);
                    value_next      = value;
                    key_next        = key;
                    pend_next       = 1'b0;
                    cmp_pend_next   = 1'b0;
                    res_pos_next    = '0;
                    res_status_next = ST_OK;
                    src_next        = '0;
                    state_next      = S_RESP;
                    case (kind_t'(kind))
                        K_INS_FRONT:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                up_next    = 1'b1;
                                pos_next   = '0;
                                mv_next    = len_reg;
                                src_next   = len_reg - ONE;
                                state_next = S_SHIFT;
                            end
                        end
                        K_INS_END:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                up_next    = 1'b1;
                                pos_next   = len_reg;
                                mv_next    = '0;
                                state_next = S_SHIFT;
                            end
                        end
                        K_INS_AFTER:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (empty)
                            begin
                                up_next    = 1'b1;
                                pos_next   = '0;
                                mv_next    = '0;
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        K_DEL_FRONT:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                up_next    = 1'b0;
                                pos_next   = '0;
                                mv_next    = len_reg - ONE;
                                src_next   = ONE;
                                state_next = S_SHIFT;
                            end
                        end
                        K_DEL_END:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                len_next = len_reg - ONE;
                            end
                        end
                        K_DEL_VALUE, K_SEARCH:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        K_DUMP:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end

            // Walk the list one read per cycle; compare the previous read.
            S_SCAN:
            begin
                if (cmp_pend_reg && (ram_rdata == target))
                begin
                    cmp_pend_next = 1'b0;
                    pend_next     = 1'b0;
                    case (kind_reg)
                        K_INS_AFTER:
                        begin
                            up_next    = 1'b1;
                            pos_next   = cmp_inc;
                            mv_next    = len_reg - cmp_inc;
                            src_next   = len_reg - ONE;
                            state_next = S_SHIFT;
                        end
                        K_DEL_VALUE:
                        begin
                            up_next    = 1'b0;
                            pos_next   = cmp_idx_reg;
                            mv_next    = len_reg - cmp_inc;
                            src_next   = cmp_inc;
                            state_next = S_SHIFT;
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                            res_pos_next    = POS_W'(cmp_inc);
                            state_next      = S_RESP;
                        end
                    endcase
                end
                else if (src_reg < len_reg)
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = src_reg[AW-1:0];
                    cmp_pend_next = 1'b1;
                    cmp_idx_next  = src_reg;
                    src_next      = src_inc;
                end
                else
                begin
                    cmp_pend_next   = 1'b0;
                    res_status_next = ST_NOTFOUND;
                    state_next      = S_RESP;
                end
            end

            // Move entries one place, a read and a write each cycle.
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = dst_reg;
                    ram_wdata = ram_rdata;
                end
                if (mv_reg != '0)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = src_reg[AW-1:0];
                    pend_next = 1'b1;
                    dst_next  = up_reg ? src_inc[AW-1:0] : src_dec[AW-1:0];
                    src_next  = up_reg ? src_dec : src_inc;
                    mv_next   = mv_reg - ONE;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (up_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pos_reg[AW-1:0];
                            ram_wdata = value_reg;
                            len_next  = len_reg + ONE;
                        end
                        else
                        begin
                            len_next = len_reg - ONE;
                        end
                        res_status_next = ST_OK;
                        state_next      = S_RESP;
                    end
                end
            end

            // Dump: read one entry, then hand it to the output register.
            S_DUMP_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = src_reg[AW-1:0];
                state_next = S_DUMP_OUT;
            end

            S_DUMP_OUT:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = ST_OK;
                    rsp_pos_next    = '0;
                    rsp_entry_next  = ram_rdata;
                    rsp_last_next   = dump_last;
                    src_next        = src_inc;
                    state_next      = dump_last ? S_IDLE : S_DUMP_RD;
                end
            end

            // Single result word of a non-dump operation.
            S_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_pos_next    = res_pos_reg;
                    rsp_entry_next  = '0;
                    rsp_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            cmp_pend_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            pend_reg       <= pend_next;
            cmp_pend_reg   <= cmp_pend_next;
            rsp_valid_reg  <= rsp_valid_next;
            kind_reg       <= kind_next;
            value_reg      <= value_next;
            key_reg        <= key_next;
            src_reg        <= src_next;
            mv_reg         <= mv_next;
            pos_reg        <= pos_next;
            cmp_idx_reg    <= cmp_idx_next;
            dst_reg        <= dst_next;
            up_reg         <= up_next;
            res_status_reg <= res_status_next;
            res_pos_reg    <= res_pos_next;
            rsp_status_reg <= rsp_status_next;
            rsp_pos_reg    <= rsp_pos_next;
            rsp_entry_reg  <= rsp_entry_next;
            rsp_last_reg   <= rsp_last_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = rsp_status_reg;
    assign position  = rsp_pos_reg;
    assign entry     = rsp_entry_reg;
    assign last      = rsp_last_reg;

    // The length never passes the capacity.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_MAX)
        else $error("list length above capacity");

    // A read and a write in the same cycle never touch the same entry.
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write to the same entry");

    // The closing write of an insert only happens with room left.
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && up_reg && mv_reg == '0 && !pend_reg)
            |-> (len_reg < LEN_MAX))
        else $error("insert completed into a full list");

    // A dump only hands out entries below the length.
    a_dump_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP_OUT) |-> (src_reg < len_reg))
        else $error("dump beyond the list length");

endmodule
